@@ hdl/mds_pkg.sv @@
// Shared types and constants for the masked difference statistics block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mds_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = 17;
  localparam int CNT_W      = 17;
  localparam int SUM_W      = 34;
  localparam int ABS_W      = 33;
  localparam int SQ_W       = 48;
  localparam int PROD_W     = 64;
  localparam int OPB_W      = 33;
  localparam int STEP_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int MUL_STEPS  = 33;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 16;

  localparam int DEF_MAX_POINTS  = 65536;
  localparam int DEF_SAMPLE_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISSING_A = 3'd0,
    CFG_BAD_A     = 3'd1,
    CFG_MISSING_B = 3'd2,
    CFG_BAD_B     = 3'd3,
    CFG_SIG_DIFF  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_BOTH_VALID = 2'd0,
    CLS_BOTH_BAD   = 2'd1,
    CLS_FIRST_BAD  = 2'd2,
    CLS_SECOND_BAD = 2'd3
  } point_cls_e;

  // Operations of the shared multi-cycle arithmetic engine, in run order.
  typedef enum logic [2:0] {
    OP_MUL_NS2  = 3'd0,
    OP_MUL_S1S1 = 3'd1,
    OP_MUL_NN   = 3'd2,
    OP_DIV_VAR  = 3'd3,
    OP_SQRT_SD  = 3'd4,
    OP_DIV_MS   = 3'd5,
    OP_SQRT_RMS = 3'd6,
    OP_DIV_MEAN = 3'd7
  } op_e;

  typedef struct packed {
    logic accept;
    logic start;
    op_e  op;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic eng_done;
    logic out_free;
    logic zero_n;
  } sts_t;

endpackage

@@ hdl/mds_ctrl.sv @@
// Controller state machine: request acceptance and sequencing of the summary math.
// Depends on mds_pkg; drives the datapath through cmd_t and reads sts_t.
module mds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_point_i,
  input  mds_pkg::sts_t sts_i,
  output mds_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DRAIN  = 2'd1,
    S_RUN    = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  state_e         state_q;
  logic           start_q;
  mds_pkg::op_e   op_q;
  logic           accept;

  function automatic mds_pkg::op_e next_op(input mds_pkg::op_e op);
    mds_pkg::op_e r;
    case (op)
      mds_pkg::OP_MUL_NS2:  r = mds_pkg::OP_MUL_S1S1;
      mds_pkg::OP_MUL_S1S1: r = mds_pkg::OP_MUL_NN;
      mds_pkg::OP_MUL_NN:   r = mds_pkg::OP_DIV_VAR;
      mds_pkg::OP_DIV_VAR:  r = mds_pkg::OP_SQRT_SD;
      mds_pkg::OP_SQRT_SD:  r = mds_pkg::OP_DIV_MS;
      mds_pkg::OP_DIV_MS:   r = mds_pkg::OP_SQRT_RMS;
      mds_pkg::OP_SQRT_RMS: r = mds_pkg::OP_DIV_MEAN;
      default:              r = mds_pkg::OP_DIV_MEAN;
    endcase
    return r;
  endfunction

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.accept = accept;
    cmd_o.start  = start_q;
    cmd_o.op     = op_q;
    cmd_o.finish = (state_q == S_FINISH) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      op_q    <= mds_pkg::OP_MUL_NS2;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && last_point_i) begin
            state_q <= S_DRAIN;
          end
        end
        // The drain state lets the last square reach the square sum.
        S_DRAIN: begin
          if (sts_i.zero_n) begin
            state_q <= S_FINISH;
          end else begin
            state_q <= S_RUN;
            op_q    <= mds_pkg::OP_MUL_NS2;
            start_q <= 1'b1;
          end
        end
        S_RUN: begin
          if (sts_i.eng_done) begin
            if (op_q == mds_pkg::OP_DIV_MEAN) begin
              state_q <= S_FINISH;
            end else begin
              op_q    <= next_op(op_q);
              start_q <= 1'b1;
            end
          end
        end
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_point_i |=> in_stall_o)
    else $error("request taken right after a last point");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.eng_done |-> state_q == S_RUN)
    else $error("engine finished outside the run phase");

  a_start_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> state_q == S_RUN && !accept)
    else $error("engine started while requests are taken");

endmodule

@@ hdl/mds_dpath.sv @@
// Datapath: configuration, classification, level accumulators, the shared
// multiply/divide/square-root engine and the result register. Depends on mds_pkg.
module mds_dpath #(
  parameter int MaxPoints  = mds_pkg::DEF_MAX_POINTS,
  parameter int SampleBits = mds_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mds_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [mds_pkg::SAMPLE_W-1:0]           cfg_data_i,
  input  logic signed [mds_pkg::SAMPLE_W-1:0]    sample_a_i,
  input  logic signed [mds_pkg::SAMPLE_W-1:0]    sample_b_i,
  input  logic                                   last_point_i,
  input  mds_pkg::cmd_t                          cmd_i,
  output mds_pkg::sts_t                          sts_o,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [1:0]                             point_class_o,
  output logic signed [mds_pkg::DIFF_W-1:0]      difference_o,
  output logic                                   summary_valid_o,
  output logic [mds_pkg::CNT_W-1:0]              diff_count_o,
  output logic [mds_pkg::CNT_W-1:0]              good_count_o,
  output logic [mds_pkg::CNT_W-1:0]              first_bad_count_o,
  output logic [mds_pkg::CNT_W-1:0]              second_bad_count_o,
  output logic signed [32:0]                     total_diff_o,
  output logic [31:0]                            total_abs_diff_o,
  output logic signed [mds_pkg::DIFF_W-1:0]      mean_diff_o,
  output logic [15:0]                            std_diff_o,
  output logic [15:0]                            rms_diff_o
);

  localparam logic [mds_pkg::CNT_W-1:0] MaxCnt = mds_pkg::CNT_W'(MaxPoints);

  // Configuration registers.
  logic [mds_pkg::SAMPLE_W-1:0] miss_a_q, bad_a_q, miss_b_q, bad_b_q, sig_q;

  // Level state.
  logic [mds_pkg::CNT_W-1:0]  good_q, signif_q, fbad_q, sbad_q;
  logic signed [mds_pkg::SUM_W-1:0] sum_q;
  logic [mds_pkg::ABS_W-1:0]  abs_q;
  logic [mds_pkg::SQ_W-1:0]   sq_sum_q;
  logic [31:0]                sq_q;
  logic                       sq_en_q;

  // Stashed item result for the last point.
  logic [1:0]                       itm_cls_q;
  logic signed [mds_pkg::DIFF_W-1:0] itm_diff_q;

  // Engine.
  logic [mds_pkg::PROD_W-1:0] eng_a_q, eng_acc_q, ld_a, ld_acc, nx_a, nx_acc;
  logic [mds_pkg::OPB_W-1:0]  eng_b_q, ld_b, nx_b;
  logic [mds_pkg::STEP_W-1:0] cnt_q, ld_cnt;
  logic                       eng_busy_q, eng_done_q;
  mds_pkg::op_e               eng_op_q;
  logic [mds_pkg::PROD_W-1:0] var_q;
  logic [mds_pkg::OPB_W-1:0]  nn_q;
  logic [15:0]                sd_q, rms_q;
  logic signed [mds_pkg::DIFF_W-1:0] mean_q;

  logic                       out_valid_q;

  // Item classification signals.
  logic signed [mds_pkg::SAMPLE_W-1:0] a_s, b_s;
  logic                                bad_a, bad_b, valid_pt;
  logic [1:0]                          cls;
  logic signed [mds_pkg::DIFF_W-1:0]   diff;
  logic [mds_pkg::DIFF_W-1:0]          ad;
  logic [mds_pkg::SUM_W-1:0]           s1abs;
  logic                                out_free, zero_n;
  logic [mds_pkg::SUM_W-1:0]           rem_sh, rem_sub;
  logic [mds_pkg::OPB_W:0]             sq_try;
  logic                                div_ge, sq_ge;

  function automatic logic signed [mds_pkg::SAMPLE_W-1:0] sext(
    input logic [mds_pkg::SAMPLE_W-1:0] v
  );
    logic [mds_pkg::SAMPLE_W-1:0] r;
    for (int i = 0; i < mds_pkg::SAMPLE_W; i++) begin
      r[i] = (i < SampleBits) ? v[i] : v[SampleBits-1];
    end
    return r;
  endfunction

  assign a_s   = sext(sample_a_i);
  assign b_s   = sext(sample_b_i);
  assign bad_a = (a_s == sext(miss_a_q)) || (a_s == sext(bad_a_q));
  assign bad_b = (b_s == sext(miss_b_q)) || (b_s == sext(bad_b_q));
  assign diff  = (bad_a || bad_b) ? '0 :
                 (mds_pkg::DIFF_W'(a_s) - mds_pkg::DIFF_W'(b_s));
  assign ad    = diff[mds_pkg::DIFF_W-1] ? mds_pkg::DIFF_W'(-diff) : diff;
  assign valid_pt = !bad_a && !bad_b;

  always_comb begin
    if (bad_a && bad_b) begin
      cls = mds_pkg::CLS_BOTH_BAD;
    end else if (bad_a) begin
      cls = mds_pkg::CLS_FIRST_BAD;
    end else if (bad_b) begin
      cls = mds_pkg::CLS_SECOND_BAD;
    end else begin
      cls = mds_pkg::CLS_BOTH_VALID;
    end
  end

  assign s1abs    = sum_q[mds_pkg::SUM_W-1] ? mds_pkg::SUM_W'(-sum_q) : sum_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign zero_n   = (good_q == '0);

  always_comb begin
    sts_o.eng_done = eng_done_q;
    sts_o.out_free = out_free;
    sts_o.zero_n   = zero_n;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_a_q <= 16'h8000;
      bad_a_q  <= 16'h8000;
      miss_b_q <= 16'h8000;
      bad_b_q  <= 16'h8000;
      sig_q    <= '0;
    end else if (cfg_we_i) begin
      case (mds_pkg::cfg_idx_e'(cfg_index_i))
        mds_pkg::CFG_MISSING_A: miss_a_q <= cfg_data_i;
        mds_pkg::CFG_BAD_A:     bad_a_q  <= cfg_data_i;
        mds_pkg::CFG_MISSING_B: miss_b_q <= cfg_data_i;
        mds_pkg::CFG_BAD_B:     bad_b_q  <= cfg_data_i;
        mds_pkg::CFG_SIG_DIFF:  sig_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Level accumulators. The square is registered and folded in during the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q   <= '0;
      signif_q <= '0;
      fbad_q   <= '0;
      sbad_q   <= '0;
      sum_q    <= '0;
      abs_q    <= '0;
      sq_sum_q <= '0;
      sq_en_q  <= 1'b0;
    end else begin
      sq_en_q <= 1'b0;
      if (sq_en_q) begin
        sq_sum_q <= sq_sum_q + mds_pkg::SQ_W'(sq_q);
      end
      if (cmd_i.finish) begin
        good_q   <= '0;
        signif_q <= '0;
        fbad_q   <= '0;
        sbad_q   <= '0;
        sum_q    <= '0;
        abs_q    <= '0;
        sq_sum_q <= '0;
      end else if (cmd_i.accept) begin
        if (cls == mds_pkg::CLS_FIRST_BAD && fbad_q < MaxCnt) begin
          fbad_q <= fbad_q + 1'b1;
        end
        if (cls == mds_pkg::CLS_SECOND_BAD && sbad_q < MaxCnt) begin
          sbad_q <= sbad_q + 1'b1;
        end
        if (valid_pt && good_q < MaxCnt) begin
          good_q  <= good_q + 1'b1;
          if (ad > {1'b0, sig_q}) begin
            signif_q <= signif_q + 1'b1;
          end
          sum_q   <= sum_q + mds_pkg::SUM_W'(diff);
          abs_q   <= abs_q + mds_pkg::ABS_W'(ad);
          sq_en_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sq_q       <= ad[15:0] * ad[15:0];
      itm_cls_q  <= cls;
      itm_diff_q <= diff;
    end
  end

  // Engine operand load.
  always_comb begin
    ld_a   = '0;
    ld_b   = '0;
    ld_acc = '0;
    ld_cnt = mds_pkg::STEP_W'(mds_pkg::MUL_STEPS);
    case (cmd_i.op)
      mds_pkg::OP_MUL_NS2: begin
        ld_a = mds_pkg::PROD_W'(sq_sum_q);
        ld_b = mds_pkg::OPB_W'(good_q);
      end
      mds_pkg::OP_MUL_S1S1: begin
        ld_a = mds_pkg::PROD_W'(s1abs);
        ld_b = s1abs[mds_pkg::OPB_W-1:0];
      end
      mds_pkg::OP_MUL_NN: begin
        ld_a = mds_pkg::PROD_W'(good_q);
        ld_b = mds_pkg::OPB_W'(good_q);
      end
      mds_pkg::OP_DIV_VAR: begin
        ld_a   = var_q;
        ld_b   = nn_q;
        ld_cnt = mds_pkg::STEP_W'(mds_pkg::DIV_STEPS);
      end
      mds_pkg::OP_DIV_MS: begin
        ld_a   = mds_pkg::PROD_W'(sq_sum_q);
        ld_b   = mds_pkg::OPB_W'(good_q);
        ld_cnt = mds_pkg::STEP_W'(mds_pkg::DIV_STEPS);
      end
      mds_pkg::OP_DIV_MEAN: begin
        ld_a   = mds_pkg::PROD_W'(s1abs);
        ld_b   = mds_pkg::OPB_W'(good_q);
        ld_cnt = mds_pkg::STEP_W'(mds_pkg::DIV_STEPS);
      end
      mds_pkg::OP_SQRT_SD, mds_pkg::OP_SQRT_RMS: begin
        // The quotient of the preceding division is still in eng_a_q.
        ld_a   = mds_pkg::PROD_W'(eng_a_q[31:0]);
        ld_b   = mds_pkg::OPB_W'(1) << 30;
        ld_cnt = mds_pkg::STEP_W'(mds_pkg::SQRT_STEPS);
      end
      default: ;
    endcase
  end

  // One engine step: shift-add multiply, restoring divide or digit-by-digit root.
  always_comb begin
    rem_sh  = {eng_acc_q[mds_pkg::OPB_W-1:0], eng_a_q[mds_pkg::PROD_W-1]};
    div_ge  = rem_sh >= mds_pkg::SUM_W'(eng_b_q);
    rem_sub = rem_sh - mds_pkg::SUM_W'(eng_b_q);
    sq_try  = {1'b0, eng_acc_q[mds_pkg::OPB_W-1:0]} + {1'b0, eng_b_q};
    sq_ge   = {1'b0, eng_a_q[mds_pkg::OPB_W-1:0]} >= sq_try;
    nx_a    = eng_a_q;
    nx_b    = eng_b_q;
    nx_acc  = eng_acc_q;
    case (eng_op_q)
      mds_pkg::OP_MUL_NS2, mds_pkg::OP_MUL_S1S1, mds_pkg::OP_MUL_NN: begin
        nx_acc = eng_acc_q + (eng_b_q[0] ? eng_a_q : '0);
        nx_a   = eng_a_q << 1;
        nx_b   = eng_b_q >> 1;
      end
      mds_pkg::OP_DIV_VAR, mds_pkg::OP_DIV_MS, mds_pkg::OP_DIV_MEAN: begin
        nx_acc = mds_pkg::PROD_W'(div_ge ? rem_sub : rem_sh);
        nx_a   = {eng_a_q[mds_pkg::PROD_W-2:0], div_ge};
      end
      mds_pkg::OP_SQRT_SD, mds_pkg::OP_SQRT_RMS: begin
        if (sq_ge) begin
          nx_a   = eng_a_q - mds_pkg::PROD_W'(sq_try);
          nx_acc = (eng_acc_q >> 1) + mds_pkg::PROD_W'(eng_b_q);
        end else begin
          nx_acc = eng_acc_q >> 1;
        end
        nx_b = eng_b_q >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_busy_q <= 1'b0;
      eng_done_q <= 1'b0;
      cnt_q      <= '0;
      eng_op_q   <= mds_pkg::OP_MUL_NS2;
    end else begin
      eng_done_q <= 1'b0;
      if (cmd_i.start) begin
        eng_busy_q <= 1'b1;
        cnt_q      <= ld_cnt;
        eng_op_q   <= cmd_i.op;
      end else if (eng_busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mds_pkg::STEP_W'(1)) begin
          eng_busy_q <= 1'b0;
          eng_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      eng_a_q   <= ld_a;
      eng_b_q   <= ld_b;
      eng_acc_q <= ld_acc;
    end else if (eng_busy_q) begin
      eng_a_q   <= nx_a;
      eng_b_q   <= nx_b;
      eng_acc_q <= nx_acc;
    end
    if (eng_done_q) begin
      case (eng_op_q)
        mds_pkg::OP_MUL_NS2:  var_q  <= eng_acc_q;
        mds_pkg::OP_MUL_S1S1: var_q  <= var_q - eng_acc_q;
        mds_pkg::OP_MUL_NN:   nn_q   <= eng_acc_q[mds_pkg::OPB_W-1:0];
        mds_pkg::OP_SQRT_SD:  sd_q   <= eng_acc_q[15:0];
        mds_pkg::OP_SQRT_RMS: rms_q  <= eng_acc_q[15:0];
        mds_pkg::OP_DIV_MEAN: begin
          mean_q <= sum_q[mds_pkg::SUM_W-1] ? mds_pkg::DIFF_W'(-eng_a_q[16:0])
                                            : eng_a_q[16:0];
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !last_point_i) || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !last_point_i) begin
      point_class_o      <= cls;
      difference_o       <= diff;
      summary_valid_o    <= 1'b0;
      diff_count_o       <= '0;
      good_count_o       <= '0;
      first_bad_count_o  <= '0;
      second_bad_count_o <= '0;
      total_diff_o       <= '0;
      total_abs_diff_o   <= '0;
      mean_diff_o        <= '0;
      std_diff_o         <= '0;
      rms_diff_o         <= '0;
    end else if (cmd_i.finish) begin
      point_class_o      <= itm_cls_q;
      difference_o       <= itm_diff_q;
      summary_valid_o    <= 1'b1;
      diff_count_o       <= signif_q;
      good_count_o       <= good_q;
      first_bad_count_o  <= fbad_q;
      second_bad_count_o <= sbad_q;
      total_diff_o       <= sum_q[32:0];
      total_abs_diff_o   <= abs_q[31:0];
      mean_diff_o        <= zero_n ? '0 : mean_q;
      std_diff_o         <= zero_n ? '0 : sd_q;
      rms_diff_o         <= zero_n ? '0 : rms_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !eng_busy_q && !eng_done_q)
    else $error("engine restarted while busy");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !eng_busy_q && !cmd_i.finish)
    else $error("request taken during summary work");

  a_finish_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !sq_en_q && !eng_busy_q)
    else $error("summary loaded before the square sum settled");

endmodule

@@ hdl/masked_difference_statistics.sv @@
// Top level of the masked difference statistics block.
// Depends on mds_pkg, mds_ctrl and mds_dpath.
//
// Each request carries a pair of 16-bit signed samples (4 fraction bits) and
// a last-point flag. A sample equal to its grid's missing or bad marker is
// invalid; the pair is classified and, when both are valid, its difference is
// output and added into the level's sum, absolute sum and square sum. An
// ordinary point's result goes straight into the result register, and a new
// request is taken every cycle as long as the result register is empty or being
// drained. On the last point the block stops taking requests while one shared
// engine runs shift-add multiplies, restoring divides and bit-pair square roots
// in turn (three 33-step multiplies, three 64-step divides, two 16-step roots).
// The summary is registered in the finish state once the result register is
// free: after the last divide, or straight after the drain state when the level
// holds no valid point. The summary is then presented together with the last
// point's own result and the level state is cleared. Configuration registers
// are written through cfg_we_i / cfg_index_i / cfg_data_i; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module masked_difference_statistics #(
  parameter int MaxPoints  = mds_pkg::DEF_MAX_POINTS,
  parameter int SampleBits = mds_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mds_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mds_pkg::SAMPLE_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mds_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [mds_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          point_class_o,
  output logic signed [mds_pkg::DIFF_W-1:0]   difference_o,
  output logic                                summary_valid_o,
  output logic [mds_pkg::CNT_W-1:0]           diff_count_o,
  output logic [mds_pkg::CNT_W-1:0]           good_count_o,
  output logic [mds_pkg::CNT_W-1:0]           first_bad_count_o,
  output logic [mds_pkg::CNT_W-1:0]           second_bad_count_o,
  output logic signed [32:0]                  total_diff_o,
  output logic [31:0]                         total_abs_diff_o,
  output logic signed [mds_pkg::DIFF_W-1:0]   mean_diff_o,
  output logic [15:0]                         std_diff_o,
  output logic [15:0]                         rms_diff_o
);

  mds_pkg::cmd_t cmd;
  mds_pkg::sts_t sts;

  // The controller owns the request handshake and the summary sequence.
  mds_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .in_stall_o   (in_stall_o)
  );

  // The datapath holds configuration, level state, the arithmetic engine and
  // the result register.
  mds_dpath #(
    .MaxPoints  (MaxPoints),
    .SampleBits (SampleBits)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .sample_a_i         (sample_a_i),
    .sample_b_i         (sample_b_i),
    .last_point_i       (last_point_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .point_class_o      (point_class_o),
    .difference_o       (difference_o),
    .summary_valid_o    (summary_valid_o),
    .diff_count_o       (diff_count_o),
    .good_count_o       (good_count_o),
    .first_bad_count_o  (first_bad_count_o),
    .second_bad_count_o (second_bad_count_o),
    .total_diff_o       (total_diff_o),
    .total_abs_diff_o   (total_abs_diff_o),
    .mean_diff_o        (mean_diff_o),
    .std_diff_o         (std_diff_o),
    .rms_diff_o         (rms_diff_o)
  );

endmodule
